/* rtl/assert_macros.svh */
// assertion macros shared by the screen buffer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TSCB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define TSCB_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define TSCB_ASSERT(lbl, prop, msg)
`define TSCB_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

/* rtl/tscb_pkg.sv */
// shared types, codes and constants of the screen cell buffer
package tscb_pkg;

  // default geometry
  localparam int DEF_MAX_ROWS   = 64;
  localparam int DEF_MAX_COLS   = 128;
  localparam int DEF_RESET_ROWS = 24;
  localparam int DEF_RESET_COLS = 80;

  // stream widths
  localparam int IN_TDATA_W  = 88;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 80;
  localparam int OUT_TUSER_W = 1;
  localparam int OUT_USED_W  = 73;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // command codes on the input tuser
  localparam logic [2:0] CMD_PUT    = 3'd0;
  localparam logic [2:0] CMD_CLEAR  = 3'd1;
  localparam logic [2:0] CMD_SCROLL = 3'd2;
  localparam logic [2:0] CMD_RESIZE = 3'd3;
  localparam logic [2:0] CMD_CURSOR = 3'd4;
  localparam logic [2:0] CMD_READ   = 3'd5;

  typedef enum logic [2:0] {
    OP_PUT,
    OP_CLEAR,
    OP_SCROLL,
    OP_RESIZE,
    OP_CURSOR,
    OP_READ,
    OP_NOP
  } op_e;

  // one decoded command
  typedef struct packed {
    op_e               op;
    logic signed [8:0] row;
    logic signed [8:0] col;
    logic signed [8:0] last_row;
    logic [8:0]        height;
    logic [8:0]        width;
    logic [20:0]       glyph;
    logic [7:0]        fore;
    logic [7:0]        back;
    logic              bold;
  } item_t;

  // one stored cell
  typedef struct packed {
    logic [20:0] glyph;
    logic [7:0]  fore;
    logic [7:0]  back;
    logic        bold;
    logic        marked;
  } cell_t;

  localparam logic [20:0] BLANK_GLYPH = 21'd32;
  localparam logic [7:0]  BLANK_FORE  = 8'd7;

  localparam cell_t SPACE_CELL = '{
    glyph:  BLANK_GLYPH,
    fore:   BLANK_FORE,
    back:   8'd0,
    bold:   1'b0,
    marked: 1'b1
  };

endpackage

/* rtl/tscb_front.sv */
// command intake: unpacks and decodes requests into a short queue
`include "assert_macros.svh"

module tscb_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // row, col, last_row, height, width, glyph, fore_colour, back_colour, bold_in
  input  logic [tscb_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // cmd
  input  logic [tscb_pkg::IN_TUSER_W-1:0]     s_axis_tuser_i,
  input  logic                                accept_en_i,
  output tscb_pkg::item_t                     item_o,
  output logic                                item_valid_o,
  input  logic                                item_pop_i
);
  import tscb_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  item_t           q_mem [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  item_t           dec_item;
  logic            full;
  logic            push;
  logic            pop;

  // unpack and classify the incoming request
  always_comb begin
    dec_item.row      = s_axis_tdata_i[8:0];
    dec_item.col      = s_axis_tdata_i[17:9];
    dec_item.last_row = s_axis_tdata_i[26:18];
    dec_item.height   = s_axis_tdata_i[35:27];
    dec_item.width    = s_axis_tdata_i[44:36];
    dec_item.glyph    = s_axis_tdata_i[65:45];
    dec_item.fore     = s_axis_tdata_i[73:66];
    dec_item.back     = s_axis_tdata_i[81:74];
    dec_item.bold     = s_axis_tdata_i[82];
    case (s_axis_tuser_i)
      CMD_PUT:    dec_item.op = OP_PUT;
      CMD_CLEAR:  dec_item.op = OP_CLEAR;
      CMD_SCROLL: dec_item.op = OP_SCROLL;
      CMD_RESIZE: dec_item.op = OP_RESIZE;
      CMD_CURSOR: dec_item.op = OP_CURSOR;
      CMD_READ:   dec_item.op = OP_READ;
      default:    dec_item.op = OP_NOP;
    endcase
  end

  // queue control
  assign full            = (cnt_q == CntW'(QUEUE_DEPTH));
  assign s_axis_tready_o = !full && accept_en_i;
  assign push            = s_axis_tvalid_i && s_axis_tready_o;
  assign pop             = item_pop_i && (cnt_q != '0);
  assign item_valid_o    = (cnt_q != '0);
  assign item_o          = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ((wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = pop ? ((rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= dec_item;
    end
  end

  `TSCB_ASSERT_NEVER(a_push_when_full, push && full, "request taken into a full queue")
  `TSCB_ASSERT(a_pop_has_data, item_pop_i |-> (cnt_q != '0), "pop from an empty queue")

endmodule

/* rtl/tscb_back.sv */
// command execution: cell memory, cursor, active size and result register
`include "assert_macros.svh"

module tscb_back #(
  parameter int MAX_ROWS   = tscb_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS   = tscb_pkg::DEF_MAX_COLS,
  parameter int RESET_ROWS = tscb_pkg::DEF_RESET_ROWS,
  parameter int RESET_COLS = tscb_pkg::DEF_RESET_COLS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tscb_pkg::item_t                     item_i,
  input  logic                                item_valid_i,
  output logic                                item_pop_o,
  output logic                                accept_en_o,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // cell_glyph, cell_fore, cell_back, cell_bold, cell_marked,
  // cursor_row_now, cursor_col_now, rows_now, cols_now
  output logic [tscb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  // range_error
  output logic [tscb_pkg::OUT_TUSER_W-1:0]    m_axis_tuser_o
);
  import tscb_pkg::*;

  localparam int DEPTH   = MAX_ROWS * MAX_COLS;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RstRows = (RESET_ROWS > MAX_ROWS) ? MAX_ROWS : ((RESET_ROWS < 1) ? 1 : RESET_ROWS);
  localparam int RstCols = (RESET_COLS > MAX_COLS) ? MAX_COLS : ((RESET_COLS < 1) ? 1 : RESET_COLS);

  typedef enum logic [3:0] {
    S_SWEEP,
    S_IDLE,
    S_START,
    S_RDWAIT,
    S_MV_RD,
    S_MV_WR,
    S_BLANK,
    S_CLR,
    S_RESULT
  } state_e;

  function automatic logic [AW-1:0] cell_addr(input logic [8:0] r, input logic [8:0] c);
    cell_addr = AW'(32'(r) * MAX_COLS + 32'(c));
  endfunction

  cell_t   cell_mem [DEPTH];
  cell_t   rdata_q;
  logic    mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  cell_t   mem_wdata;

  state_e  state_q;
  item_t   cur_q;
  logic    sweep_init_q;
  logic [8:0] r_q, c_q, r_end_q, c_end_q, c_start_q;
  logic [8:0] kr_q, kc_q;
  logic [8:0] rows_q, cols_q;
  logic [7:0] curs_row_q, curs_col_q;
  cell_t   res_cell_q;
  logic    res_err_q;
  logic    out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;
  logic    out_err_q;
  logic    res_load;

  logic       row_nneg, col_nneg, last_nneg;
  logic [7:0] row_u, col_u, last_u;
  logic [7:0] rows_m1, cols_m1;
  logic [7:0] row_clamp, col_clamp, bot;
  logic       in_area;
  logic [7:0] rs, cs;
  logic signed [10:0] er_s, ec_s, er_c, ec_c;
  logic       clr_empty;
  logic [8:0] nr, nc, kr, kc;
  logic       last_col, last_row_sweep;

  // operand preparation from the current command
  always_comb begin
    row_nneg  = !cur_q.row[8];
    col_nneg  = !cur_q.col[8];
    last_nneg = !cur_q.last_row[8];
    row_u     = cur_q.row[7:0];
    col_u     = cur_q.col[7:0];
    last_u    = cur_q.last_row[7:0];
    rows_m1   = 8'(rows_q - 9'd1);
    cols_m1   = 8'(cols_q - 9'd1);

    // coordinate clamped into the active area
    row_clamp = !row_nneg ? 8'd0 : ((9'(row_u) >= rows_q) ? rows_m1 : row_u);
    col_clamp = !col_nneg ? 8'd0 : ((9'(col_u) >= cols_q) ? cols_m1 : col_u);

    // scroll bottom clamped between top and last row
    if (!last_nneg || (last_u < row_clamp)) begin
      bot = row_clamp;
    end else if (9'(last_u) >= rows_q) begin
      bot = rows_m1;
    end else begin
      bot = last_u;
    end

    in_area = row_nneg && col_nneg && (9'(row_u) < rows_q) && (9'(col_u) < cols_q);

    // clipped clear rectangle
    rs   = row_nneg ? row_u : 8'd0;
    cs   = col_nneg ? col_u : 8'd0;
    er_s = $signed({{2{cur_q.row[8]}}, cur_q.row}) + $signed({2'b00, cur_q.height});
    ec_s = $signed({{2{cur_q.col[8]}}, cur_q.col}) + $signed({2'b00, cur_q.width});
    er_c = (er_s > $signed({2'b00, rows_q})) ? $signed({2'b00, rows_q}) : er_s;
    ec_c = (ec_s > $signed({2'b00, cols_q})) ? $signed({2'b00, cols_q}) : ec_s;
    clr_empty = (er_c <= $signed({3'b000, rs})) || (ec_c <= $signed({3'b000, cs}));

    // resize counts and kept overlap
    nr = (cur_q.height == 9'd0) ? 9'd1 :
         ((32'(cur_q.height) > MAX_ROWS) ? 9'(MAX_ROWS) : cur_q.height);
    nc = (cur_q.width == 9'd0) ? 9'd1 :
         ((32'(cur_q.width) > MAX_COLS) ? 9'(MAX_COLS) : cur_q.width);
    kr = (nr < rows_q) ? nr : rows_q;
    kc = (nc < cols_q) ? nc : cols_q;

    last_col       = (c_q == 9'(MAX_COLS - 1));
    last_row_sweep = (r_q == 9'(MAX_ROWS - 1));
  end

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cell_addr(r_q, c_q);
    mem_raddr = cell_addr(9'(row_u), 9'(col_u));
    mem_wdata = SPACE_CELL;
    case (state_q)
      S_SWEEP: begin
        mem_we = (r_q >= kr_q) || (c_q >= kc_q);
      end
      S_START: begin
        if (cur_q.op == OP_PUT) begin
          mem_we    = in_area;
          mem_waddr = cell_addr(9'(row_u), 9'(col_u));
          mem_wdata = '{glyph: cur_q.glyph, fore: cur_q.fore, back: cur_q.back,
                        bold: cur_q.bold, marked: 1'b1};
        end
      end
      S_MV_RD: begin
        mem_raddr = cell_addr(r_q + 9'd1, c_q);
      end
      S_MV_WR: begin
        mem_we    = 1'b1;
        mem_wdata = rdata_q;
      end
      S_BLANK: begin
        mem_we = 1'b1;
      end
      S_CLR: begin
        mem_we    = 1'b1;
        mem_wdata = '{glyph: BLANK_GLYPH, fore: cur_q.fore, back: cur_q.back,
                      bold: cur_q.bold, marked: 1'b1};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // cell memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cell_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= cell_mem[mem_raddr];
  end

  assign item_pop_o  = (state_q == S_IDLE) && item_valid_i;
  assign accept_en_o = !sweep_init_q;

  // result register loads when it is empty or being drained
  assign res_load = (state_q == S_RESULT) && (!out_valid_q || m_axis_tready_i);

  // sequencer, state registers and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_SWEEP;
      cur_q        <= '0;
      sweep_init_q <= 1'b1;
      r_q          <= '0;
      c_q          <= '0;
      r_end_q      <= '0;
      c_end_q      <= '0;
      c_start_q    <= '0;
      kr_q         <= '0;
      kc_q         <= '0;
      rows_q       <= 9'(RstRows);
      cols_q       <= 9'(RstCols);
      curs_row_q   <= '0;
      curs_col_q   <= '0;
      res_cell_q   <= '0;
      res_err_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
      out_err_q    <= 1'b0;
    end else begin
      // output valid: set on a new result, cleared once taken
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        // walk every cell writing blanks outside the kept area
        S_SWEEP: begin
          if (last_col) begin
            c_q <= '0;
            if (last_row_sweep) begin
              r_q <= '0;
              if (sweep_init_q) begin
                sweep_init_q <= 1'b0;
                state_q      <= S_IDLE;
              end else begin
                rows_q     <= nr;
                cols_q     <= nc;
                curs_row_q <= (9'(curs_row_q) >= nr) ? 8'(nr - 9'd1) : curs_row_q;
                curs_col_q <= (9'(curs_col_q) >= nc) ? 8'(nc - 9'd1) : curs_col_q;
                state_q    <= S_RESULT;
              end
            end else begin
              r_q <= r_q + 9'd1;
            end
          end else begin
            c_q <= c_q + 9'd1;
          end
        end
        S_IDLE: begin
          if (item_valid_i) begin
            cur_q   <= item_i;
            state_q <= S_START;
          end
        end
        // first step of every command
        S_START: begin
          res_cell_q <= '0;
          res_err_q  <= 1'b0;
          case (cur_q.op)
            OP_CLEAR: begin
              r_q       <= 9'(rs);
              c_q       <= 9'(cs);
              c_start_q <= 9'(cs);
              r_end_q   <= 9'(er_c);
              c_end_q   <= 9'(ec_c);
              state_q   <= clr_empty ? S_RESULT : S_CLR;
            end
            OP_SCROLL: begin
              c_q     <= '0;
              r_end_q <= 9'(bot);
              if (row_clamp < bot) begin
                r_q     <= 9'(row_clamp);
                state_q <= S_MV_RD;
              end else begin
                r_q     <= 9'(bot);
                state_q <= S_BLANK;
              end
            end
            OP_RESIZE: begin
              r_q     <= '0;
              c_q     <= '0;
              kr_q    <= kr;
              kc_q    <= kc;
              state_q <= S_SWEEP;
            end
            OP_CURSOR: begin
              curs_row_q <= row_clamp;
              curs_col_q <= col_clamp;
              state_q    <= S_RESULT;
            end
            OP_READ: begin
              if (in_area) begin
                state_q <= S_RDWAIT;
              end else begin
                res_err_q <= 1'b1;
                state_q   <= S_RESULT;
              end
            end
            default: begin
              state_q <= S_RESULT;
            end
          endcase
        end
        S_RDWAIT: begin
          res_cell_q <= rdata_q;
          state_q    <= S_RESULT;
        end
        S_MV_RD: begin
          state_q <= S_MV_WR;
        end
        // copy one cell up a row
        S_MV_WR: begin
          state_q <= S_MV_RD;
          if (last_col) begin
            c_q <= '0;
            if (r_q + 9'd1 == r_end_q) begin
              r_q     <= r_end_q;
              state_q <= S_BLANK;
            end else begin
              r_q <= r_q + 9'd1;
            end
          end else begin
            c_q <= c_q + 9'd1;
          end
        end
        S_BLANK: begin
          if (last_col) begin
            c_q     <= '0;
            state_q <= S_RESULT;
          end else begin
            c_q <= c_q + 9'd1;
          end
        end
        S_CLR: begin
          if (c_q + 9'd1 == c_end_q) begin
            c_q <= c_start_q;
            if (r_q + 9'd1 == r_end_q) begin
              state_q <= S_RESULT;
            end else begin
              r_q <= r_q + 9'd1;
            end
          end else begin
            c_q <= c_q + 9'd1;
          end
        end
        // hand the result to the output register
        S_RESULT: begin
          if (res_load) begin
            out_err_q   <= res_err_q;
            out_data_q  <= {(OUT_TDATA_W - OUT_USED_W)'(0), cols_q, rows_q,
                            curs_col_q, curs_row_q, res_cell_q.marked, res_cell_q.bold,
                            res_cell_q.back, res_cell_q.fore, res_cell_q.glyph};
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_err_q;

  `TSCB_ASSERT(a_waddr_range, mem_we |-> (32'(mem_waddr) < DEPTH), "cell write out of store")
  `TSCB_ASSERT(a_cursor_in_area, (9'(curs_row_q) < rows_q) && (9'(curs_col_q) < cols_q), "cursor outside area")
  `TSCB_ASSERT(a_size_range, (rows_q != 9'd0) && (32'(rows_q) <= MAX_ROWS) && (cols_q != 9'd0) && (32'(cols_q) <= MAX_COLS), "active size out of range")

endmodule

/* rtl/text_screen_cell_buffer_core.sv */
// top level of the character cell screen buffer
//
// Commands arrive on the s_axis channel: the command code in tuser and its
// operands packed in tdata. Each command returns exactly one result on the
// m_axis channel, carrying the cell read (read only), a range error flag in
// tuser and the cursor and active size after the command.
// A two-entry command queue takes requests while the executor is busy.
// Put, set cursor and no-op commands finish in the start step; read adds a
// wait for the memory read. Clear, scroll and resize walk the single-port
// cell memory one cell per write cycle: clear over the clipped rectangle,
// scroll copying each row up from top to bottom and blanking the bottom row,
// resize over the whole store.
// After reset the memory is blanked in one pass over every cell, during
// which s_axis_tready_o stays low.
// A finished result waits in the output register while m_axis_tready_i is
// low; the queue keeps taking requests until it is full.
module text_screen_cell_buffer_core #(
  parameter int MAX_ROWS   = tscb_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS   = tscb_pkg::DEF_MAX_COLS,
  parameter int RESET_ROWS = tscb_pkg::DEF_RESET_ROWS,
  parameter int RESET_COLS = tscb_pkg::DEF_RESET_COLS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // row, col, last_row, height, width, glyph, fore_colour, back_colour, bold_in
  input  logic [tscb_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // cmd
  input  logic [tscb_pkg::IN_TUSER_W-1:0]     s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // cell_glyph, cell_fore, cell_back, cell_bold, cell_marked,
  // cursor_row_now, cursor_col_now, rows_now, cols_now
  output logic [tscb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  // range_error
  output logic [tscb_pkg::OUT_TUSER_W-1:0]    m_axis_tuser_o
);
  import tscb_pkg::*;

  item_t item;
  logic  item_valid;
  logic  item_pop;
  logic  accept_en;

  // request intake and queue
  tscb_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .accept_en_i     (accept_en),
    .item_o          (item),
    .item_valid_o    (item_valid),
    .item_pop_i      (item_pop)
  );

  // command executor
  tscb_back #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .RESET_ROWS (RESET_ROWS),
    .RESET_COLS (RESET_COLS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_i          (item),
    .item_valid_i    (item_valid),
    .item_pop_o      (item_pop),
    .accept_en_o     (accept_en),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

/* tb/sv/testbench.sv */
// self-checking testbench for the character cell screen buffer core
`timescale 1ns / 100ps

module testbench;
  import tscb_pkg::*;

  localparam int MAX_ROWS    = DEF_MAX_ROWS;
  localparam int MAX_COLS    = DEF_MAX_COLS;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 4_000_000;

  // spare command codes, decoded as no-ops
  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  // how both stream sides pace themselves while a request is in flight
  typedef enum int {
    PACE_STEADY,
    PACE_SRC_IDLE,
    PACE_SINK_STALL,
    PACE_BOTH,
    PACE_PRESSURE
  } pace_e;

  typedef struct {
    logic [2:0]        op;
    logic signed [8:0] row;
    logic signed [8:0] col;
    logic signed [8:0] last_row;
    logic [8:0]        height;
    logic [8:0]        width;
    logic [20:0]       glyph;
    logic [7:0]        fore;
    logic [7:0]        back;
    logic              bold;
    pace_e             pace;
  } screen_cmd_t;

  typedef struct packed {
    cell_t      data;
    logic       range_err;
    logic [7:0] cur_row;
    logic [7:0] cur_col;
    logic [8:0] rows;
    logic [8:0] cols;
  } screen_result_t;

  logic                   clk_i    = 1'b0;
  logic                   rst_ni   = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic [IN_TUSER_W-1:0]  s_tuser  = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [OUT_TUSER_W-1:0] m_tuser;

  text_screen_cell_buffer_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  // pending commands and the results they should produce
  screen_cmd_t    cmd_queue[$];
  screen_result_t expected_q[$];
  screen_cmd_t    next_cmd;
  screen_cmd_t    taken_cmd;
  screen_result_t want;

  // predicted screen state
  cell_t screen_mem [MAX_ROWS][MAX_COLS];
  int    cur_row;
  int    cur_col;
  int    act_rows;
  int    act_cols;

  // size as the stimulus generator sees it
  int gen_rows;
  int gen_cols;

  logic  req_taken = 1'b0;
  pace_e rx_pace = PACE_STEADY;
  int    hold_count = 0;
  int    cycle_count = 0;
  int    fail_count = 0;
  int    results_checked = 0;
  int    read_hits = 0;
  int    read_misses = 0;
  int    cmd_count [8];

  function automatic int clamp_int(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic bit in_area(int r, int c);
    return r >= 0 && r < act_rows && c >= 0 && c < act_cols;
  endfunction

  function automatic int full_coord();
    return int'($urandom_range(0, 511)) - 256;
  endfunction

  // apply one command to the predicted screen and return its result
  function automatic screen_result_t run_screen_cmd(screen_cmd_t c);
    screen_result_t res;
    cell_t          fill;
    int             row, col, last_row, height, width;
    int             er, ec, top, bot, keep_r, keep_c;
    row      = c.row;
    col      = c.col;
    last_row = c.last_row;
    height   = c.height;
    width    = c.width;
    res      = '0;
    fill     = '{glyph: c.glyph, fore: c.fore, back: c.back, bold: c.bold, marked: 1'b1};
    case (c.op)
      CMD_PUT: begin
        if (in_area(row, col)) screen_mem[row][col] = fill;
      end
      CMD_CLEAR: begin
        fill.glyph = BLANK_GLYPH;
        er = (row + height > act_rows) ? act_rows : row + height;
        ec = (col + width > act_cols) ? act_cols : col + width;
        for (int r = (row < 0) ? 0 : row; r < er; r++)
          for (int k = (col < 0) ? 0 : col; k < ec; k++)
            screen_mem[r][k] = fill;
      end
      CMD_SCROLL: begin
        top = clamp_int(row, 0, act_rows - 1);
        bot = clamp_int(last_row, top, act_rows - 1);
        for (int r = top; r < bot; r++)
          for (int k = 0; k < MAX_COLS; k++)
            screen_mem[r][k] = screen_mem[r + 1][k];
        for (int k = 0; k < MAX_COLS; k++)
          screen_mem[bot][k] = SPACE_CELL;
      end
      CMD_RESIZE: begin
        height = clamp_int(height, 1, MAX_ROWS);
        width  = clamp_int(width, 1, MAX_COLS);
        keep_r = (height < act_rows) ? height : act_rows;
        keep_c = (width < act_cols) ? width : act_cols;
        for (int r = 0; r < MAX_ROWS; r++)
          for (int k = 0; k < MAX_COLS; k++)
            if (r >= keep_r || k >= keep_c) screen_mem[r][k] = SPACE_CELL;
        act_rows = height;
        act_cols = width;
        cur_row  = clamp_int(cur_row, 0, act_rows - 1);
        cur_col  = clamp_int(cur_col, 0, act_cols - 1);
      end
      CMD_CURSOR: begin
        cur_row = clamp_int(row, 0, act_rows - 1);
        cur_col = clamp_int(col, 0, act_cols - 1);
      end
      CMD_READ: begin
        if (in_area(row, col)) begin
          res.data = screen_mem[row][col];
          read_hits++;
        end else begin
          res.range_err = 1'b1;
          read_misses++;
        end
      end
      default: ;
    endcase
    res.cur_row = 8'(cur_row);
    res.cur_col = 8'(cur_col);
    res.rows    = 9'(act_rows);
    res.cols    = 9'(act_cols);
    return res;
  endfunction

  task automatic check_field(string fname, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", fname, exp_v, act_v);
      fail_count++;
    end
  endtask

  task automatic add_cmd(logic [2:0] op, int row, int col, int last_row, int height,
                         int width, int glyph, int fore, int back, int bold, pace_e pace);
    screen_cmd_t c;
    c.op       = op;
    c.row      = 9'(row);
    c.col      = 9'(col);
    c.last_row = 9'(last_row);
    c.height   = 9'(height);
    c.width    = 9'(width);
    c.glyph    = 21'(glyph);
    c.fore     = 8'(fore);
    c.back     = 8'(back);
    c.bold     = 1'(bold);
    c.pace     = pace;
    if (op == CMD_RESIZE) begin
      gen_rows = clamp_int(height, 1, MAX_ROWS);
      gen_cols = clamp_int(width, 1, MAX_COLS);
    end
    cmd_queue.push_back(c);
  endtask

  // random commands: mostly inside the screen, small rectangles and bands
  task automatic add_random(int count, pace_e pace, bit fast_only);
    int         pick;
    logic [2:0] op;
    int         row, col, last_row, height, width;
    for (int n = 0; n < count; n++) begin
      pick     = $urandom_range(0, 99);
      row      = $urandom_range(0, gen_rows - 1);
      col      = $urandom_range(0, gen_cols - 1);
      last_row = row + int'($urandom_range(0, 4));
      height   = $urandom_range(0, 8);
      width    = $urandom_range(0, 8);
      if ($urandom_range(0, 7) == 0) begin
        row      = full_coord();
        col      = full_coord();
        last_row = full_coord();
      end
      if (fast_only)
        op = (pick < 45) ? CMD_PUT : (pick < 90) ? CMD_READ : CMD_CURSOR;
      else if (pick < 35) op = CMD_PUT;
      else if (pick < 70) op = CMD_READ;
      else if (pick < 80) op = CMD_CURSOR;
      else if (pick < 90) op = CMD_CLEAR;
      else if (pick < 96) op = CMD_SCROLL;
      else if (pick < 99) op = CMD_RESIZE;
      else op = $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
      // a few clears get large sizes and coordinates over the full range
      if (op == CMD_CLEAR && $urandom_range(0, 9) == 0) begin
        height = $urandom_range(0, 256);
        width  = $urandom_range(0, 256);
        row    = full_coord();
        col    = full_coord();
      end
      if (op == CMD_RESIZE) begin
        height = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 256)
                                             : $urandom_range(1, MAX_ROWS);
        width  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 256)
                                             : $urandom_range(1, MAX_COLS);
      end
      add_cmd(op, row, col, last_row, height, width, $urandom_range(0, 1114111),
              $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1), pace);
    end
  endtask

  // clock and reset
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // request driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
    end else if (req_taken || !s_tvalid) begin
      if (cmd_queue.size() != 0 &&
          $urandom_range(0, 99) >= ((cmd_queue[0].pace == PACE_SRC_IDLE) ? 48 :
                                    (cmd_queue[0].pace == PACE_BOTH) ? 31 : 0)) begin
        next_cmd = cmd_queue.pop_front();
        s_tdata  <= {5'b0, next_cmd.bold, next_cmd.back, next_cmd.fore, next_cmd.glyph,
                     next_cmd.width, next_cmd.height, next_cmd.last_row, next_cmd.col,
                     next_cmd.row};
        s_tuser  <= next_cmd.op;
        s_tvalid <= 1'b1;
        rx_pace  <= next_cmd.pace;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off to back up the command queue
  always @(negedge clk_i) begin
    if (rx_pace == PACE_PRESSURE && hold_count < HOLD_CYCLES) begin
      hold_count <= hold_count + 1;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= $urandom_range(0, 99) >= ((rx_pace == PACE_SINK_STALL) ? 48 :
                                            (rx_pace == PACE_BOTH) ? 31 : 0);
    end
  end

  // monitor: predict on accepted requests, check accepted results
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        taken_cmd.op       = s_tuser;
        taken_cmd.row      = s_tdata[8:0];
        taken_cmd.col      = s_tdata[17:9];
        taken_cmd.last_row = s_tdata[26:18];
        taken_cmd.height   = s_tdata[35:27];
        taken_cmd.width    = s_tdata[44:36];
        taken_cmd.glyph    = s_tdata[65:45];
        taken_cmd.fore     = s_tdata[73:66];
        taken_cmd.back     = s_tdata[81:74];
        taken_cmd.bold     = s_tdata[82];
        cmd_count[s_tuser]++;
        expected_q.push_back(run_screen_cmd(taken_cmd));
      end
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          $error("result with no command pending: tdata %h tuser %b", m_tdata, m_tuser);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("cell_glyph", want.data.glyph, m_tdata[20:0]);
          check_field("cell_fore", want.data.fore, m_tdata[28:21]);
          check_field("cell_back", want.data.back, m_tdata[36:29]);
          check_field("cell_bold", want.data.bold, m_tdata[37]);
          check_field("cell_marked", want.data.marked, m_tdata[38]);
          check_field("range_error", want.range_err, m_tuser[0]);
          check_field("cursor_row_now", want.cur_row, m_tdata[46:39]);
          check_field("cursor_col_now", want.cur_col, m_tdata[54:47]);
          check_field("rows_now", want.rows, m_tdata[63:55]);
          check_field("cols_now", want.cols, m_tdata[72:64]);
          results_checked++;
        end
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $error("timeout after %0d cycles, %0d results outstanding", cycle_count,
           expected_q.size());
    $display("Regression FAIL");
    $finish;
  end

  // stimulus and end of run
  initial begin
    foreach (cmd_count[i]) cmd_count[i] = 0;
    foreach (screen_mem[r, k]) screen_mem[r][k] = SPACE_CELL;
    cur_row  = 0;
    cur_col  = 0;
    act_rows = clamp_int(DEF_RESET_ROWS, 1, MAX_ROWS);
    act_cols = clamp_int(DEF_RESET_COLS, 1, MAX_COLS);
    gen_rows = act_rows;
    gen_cols = act_cols;

    // directed: corners, clipping, clamping and every command code
    add_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, PACE_STEADY);
    add_cmd(CMD_PUT, 0, 0, 0, 0, 0, 1114111, 255, 255, 1, PACE_STEADY);
    add_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, PACE_STEADY);
    add_cmd(CMD_PUT, 23, 79, 0, 0, 0, 983040, 0, 0, 0, PACE_STEADY);
    add_cmd(CMD_READ, 23, 79, 0, 0, 0, 0, 0, 0, 0, PACE_STEADY);
    add_cmd(CMD_PUT, -1, 5, 0, 0, 0, 65, 1, 1, 1, PACE_STEADY);
    add_cmd(CMD_PUT, 24, 0, 0, 0, 0, 66, 1, 1, 1, PACE_STEADY);
    add_cmd(CMD_PUT, 255, 255, 0, 0, 0, 67, 1, 1, 1, PACE_STEADY);
    add_cmd(CMD_PUT, -256, -256, 0, 0, 0, 68, 1, 1, 1, PACE_STEADY);
    add_cmd(CMD_READ, -256, -256, 0, 0, 0, 0, 0, 0, 0, PACE_STEADY);
    add_cmd(CMD_READ, 0, 80, 0, 0, 0, 0, 0, 0, 0, PACE_STEADY);
    add_cmd(CMD_CLEAR, -2, 78, 0, 4, 5, 0, 1, 2, 1, PACE_STEADY);
    add_cmd(CMD_READ, 1, 79, 0, 0, 0, 0, 0, 0, 0, PACE_STEADY);
    add_cmd(CMD_CLEAR, 30, 0, 0, 2, 2, 0, 3, 4, 0, PACE_STEADY);
    add_cmd(CMD_CLEAR, 5, 5, 0, 0, 256, 0, 3, 4, 0, PACE_STEADY);
    add_cmd(CMD_SCROLL, -5, 0, 1, 0, 0, 0, 0, 0, 0, PACE_STEADY);
    add_cmd(CMD_READ, 0, 79, 0, 0, 0, 0, 0, 0, 0, PACE_STEADY);
    add_cmd(CMD_SCROLL, 10, 0, 5, 0, 0, 0, 0, 0, 0, PACE_STEADY);
    add_cmd(CMD_SCROLL, 255, 0, -256, 0, 0, 0, 0, 0, 0, PACE_STEADY);
    add_cmd(CMD_CURSOR, -256, 255, 0, 0, 0, 0, 0, 0, 0, PACE_STEADY);
    add_cmd(CMD_RESIZE, 0, 0, 0, 0, 0, 0, 0, 0, 0, PACE_STEADY);
    add_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, PACE_STEADY);
    add_cmd(CMD_RESIZE, 0, 0, 0, 256, 256, 0, 0, 0, 0, PACE_STEADY);
    add_cmd(CMD_CURSOR, 255, 255, 0, 0, 0, 0, 0, 0, 0, PACE_STEADY);
    add_cmd(CMD_READ, 63, 127, 0, 0, 0, 0, 0, 0, 0, PACE_STEADY);
    add_cmd(CMD_SPARE_LO, 1, 1, 1, 1, 1, 1, 1, 1, 1, PACE_STEADY);
    add_cmd(CMD_SPARE_HI, 2, 2, 2, 2, 2, 2, 2, 2, 0, PACE_STEADY);
    add_cmd(CMD_RESIZE, 0, 0, 0, 24, 80, 0, 0, 0, 0, PACE_STEADY);

    // random phases with different flow control on each side
    add_random(170, PACE_STEADY, 1'b0);
    add_random(60, PACE_PRESSURE, 1'b1);
    add_random(200, PACE_SRC_IDLE, 1'b0);
    add_random(200, PACE_SINK_STALL, 1'b0);
    add_random(200, PACE_BOTH, 1'b0);

    // drain, then give a stray result time to show up
    while (cmd_queue.size() != 0 || s_tvalid || expected_q.size() != 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("covered %0d put, %0d clear, %0d scroll, %0d resize, %0d cursor, %0d read, %0d spare",
             cmd_count[CMD_PUT], cmd_count[CMD_CLEAR], cmd_count[CMD_SCROLL],
             cmd_count[CMD_RESIZE], cmd_count[CMD_CURSOR], cmd_count[CMD_READ],
             cmd_count[CMD_SPARE_LO] + cmd_count[CMD_SPARE_HI]);
    $display("reads inside %0d, outside %0d; %0d results checked over %0d cycles",
             read_hits, read_misses, results_checked, cycle_count);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/tscb_pkg.sv
rtl/tscb_front.sv
rtl/tscb_back.sv
rtl/text_screen_cell_buffer_core.sv
tb/sv/testbench.sv
